FILE: hw/rtl/ubdc_pkg.sv
package ubdc_pkg;

   localparam int BAUD_W      = 24;
   localparam int PCLK_W      = 28;
   localparam int PROD_W      = PCLK_W + 5;
   localparam int QUO_W       = 32;
   localparam int DIV_STEPS   = QUO_W;
   localparam int WORD_W      = 16;
   localparam int MANT_W      = 12;
   localparam int MANT_FULL_W = 27;
   localparam int REM_W       = 7;
   localparam int FRAC_W      = 4;
   localparam int FRAC_X_W    = 11;
   localparam int FRAC_P_W    = 24;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [PCLK_W-1:0]   PCLK_RESET       = 28'd16000000;
   localparam logic [QUO_W-1:0]    RECIP_100        = 32'd1374389535;
   localparam int                  RECIP_100_SHIFT  = 37;
   localparam logic [12:0]         RECIP_FRAC       = 13'd5243;
   localparam int                  RECIP_FRAC_SHIFT = 19;
   localparam logic [FRAC_X_W-1:0] ROUND_HALF       = 11'd50;
   localparam logic [REM_W-1:0]    DEC_BASE         = 7'd100;

   typedef enum logic {
      REG_PCLK_HZ    = 1'b0,
      REG_OVERSAMPLE = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [BAUD_W-1:0] rem;
      logic [QUO_W-1:0]  quo;
      logic [BAUD_W-1:0] divisor;
      logic              os8;
      logic              zero;
   } div_stage_type;

endpackage

FILE: hw/rtl/uart_baud_divider_calc_unit.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_baud_rate[23:0]
// rsp       out        rsp_valid/rsp_stall  rsp_divider_word[15:0], rsp_zero_baud_error,
//                                           rsp_mantissa_overflow
// csr       in/out     psel/penable/pready  paddr[2:0], pwdata/prdata[31:0], pwrite
//
// one item per cycle when not stalled (input stage, 32 restoring divide stages
// at one quotient bit each, reciprocal multiply, remainder, output register)
// reset is synchronous; it clears all valid bits and os8_ff, sets pclk_ff to 16000000
// rsp_stall freezes the whole pipeline while rsp_valid is high; req_stall is
// high while the output register holds a stalled item, so nothing is lost or repeated
module uart_baud_divider_calc_unit
   import ubdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BAUD_W-1:0]     req_baud_rate,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [WORD_W-1:0]     rsp_divider_word,
   output logic                  rsp_zero_baud_error,
   output logic                  rsp_mantissa_overflow,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [PCLK_W-1:0] pclk_ff;
   logic              os8_ff;
   reg_index_type     csr_index;
   logic              csr_write;

   div_stage_type     dv_ff    [DIV_STEPS+1];
   div_stage_type     dv_in    [DIV_STEPS+1];
   logic              dv_valid_ff [DIV_STEPS+1];
   logic [BAUD_W:0]   trial    [DIV_STEPS];
   logic              qbit     [DIV_STEPS];

   logic [PROD_W-1:0] prod25;
   logic [QUO_W-1:0]  numer;

   logic [2*QUO_W-1:0]     mu_prod;
   logic                   mu_valid_ff;
   logic [MANT_FULL_W-1:0] mu_mant_ff;
   logic [REM_W-1:0]       mu_dlo_ff;
   logic                   mu_os8_ff;
   logic                   mu_zero_ff;

   logic [REM_W-1:0]       hundred_lo;
   logic                   rm_valid_ff;
   logic [MANT_FULL_W-1:0] rm_mant_ff;
   logic [REM_W-1:0]       rm_rem_ff;
   logic [REM_W-1:0]       rm_rem_in;
   logic                   rm_os8_ff;
   logic                   rm_zero_ff;

   logic [FRAC_X_W-1:0]    frac_x;
   logic [FRAC_P_W-1:0]    frac_p;
   logic [FRAC_W:0]        frac_q;
   logic [FRAC_W-1:0]      frac;

   logic                   rsp_valid_ff;
   logic [WORD_W-1:0]      rsp_word_ff;
   logic                   rsp_zero_ff;
   logic                   rsp_ovf_ff;
   logic                   rsp_os8_ff;
   logic [WORD_W-1:0]      rsp_word_in;
   logic                   rsp_ovf_in;

   logic                   advance;

   // csr port
   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      unique case (csr_index)
         REG_PCLK_HZ:    prdata = {{(CSR_DATA_W-PCLK_W){1'b0}}, pclk_ff};
         REG_OVERSAMPLE: prdata = {{(CSR_DATA_W-1){1'b0}}, os8_ff};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pclk_ff <= PCLK_RESET;
         os8_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_PCLK_HZ:    pclk_ff <= pwdata[PCLK_W-1:0];
            REG_OVERSAMPLE: os8_ff  <= pwdata[0];
            default:        ;
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // dividend 25*pclk/k, with k folded in as a right shift
   assign prod25 = ({5'b0, pclk_ff} << 4) + ({5'b0, pclk_ff} << 3) + {5'b0, pclk_ff};
   assign numer  = os8_ff ? prod25[PROD_W-1:1] : {1'b0, prod25[PROD_W-1:2]};

   always_comb begin
      dv_in[0].rem     = '0;
      dv_in[0].quo     = numer;
      dv_in[0].divisor = req_baud_rate;
      dv_in[0].os8     = os8_ff;
      dv_in[0].zero    = (req_baud_rate == '0);
      for (int s = 0; s < DIV_STEPS; s++) begin
         trial[s] = {dv_ff[s].rem, dv_ff[s].quo[QUO_W-1]};
         qbit[s]  = (trial[s] >= {1'b0, dv_ff[s].divisor});
         dv_in[s+1].rem     = qbit[s] ? BAUD_W'(trial[s] - {1'b0, dv_ff[s].divisor})
                                      : trial[s][BAUD_W-1:0];
         dv_in[s+1].quo     = {dv_ff[s].quo[QUO_W-2:0], qbit[s]};
         dv_in[s+1].divisor = dv_ff[s].divisor;
         dv_in[s+1].os8     = dv_ff[s].os8;
         dv_in[s+1].zero    = dv_ff[s].zero;
      end
   end

   // d/100 by reciprocal
   assign mu_prod = {{QUO_W{1'b0}}, dv_ff[DIV_STEPS].quo} * {{QUO_W{1'b0}}, RECIP_100};

   // d mod 100 fits in 7 bits, so only the low bits of 100*mant matter
   assign hundred_lo = {mu_mant_ff[0], 6'b0} + {mu_mant_ff[1:0], 5'b0}
                     + {mu_mant_ff[4:0], 2'b0};
   assign rm_rem_in  = mu_dlo_ff - hundred_lo;

   // rounded fraction, carry dropped by the mask
   assign frac_x = (rm_os8_ff ? {1'b0, rm_rem_ff, 3'b0} : {rm_rem_ff, 4'b0}) + ROUND_HALF;
   assign frac_p = {{(FRAC_P_W-FRAC_X_W){1'b0}}, frac_x}
                 * {{(FRAC_P_W-13){1'b0}}, RECIP_FRAC};
   assign frac_q = frac_p[RECIP_FRAC_SHIFT +: FRAC_W+1];
   assign frac   = rm_os8_ff ? {1'b0, frac_q[2:0]} : frac_q[FRAC_W-1:0];

   assign rsp_word_in = rm_zero_ff ? '0 : {rm_mant_ff[MANT_W-1:0], frac};
   assign rsp_ovf_in  = !rm_zero_ff && (|rm_mant_ff[MANT_FULL_W-1:MANT_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STEPS; s++) begin
            dv_valid_ff[s] <= 1'b0;
         end
         mu_valid_ff  <= 1'b0;
         rm_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         dv_valid_ff[0] <= req_valid;
         for (int s = 0; s < DIV_STEPS; s++) begin
            dv_valid_ff[s+1] <= dv_valid_ff[s];
         end
         mu_valid_ff  <= dv_valid_ff[DIV_STEPS];
         rm_valid_ff  <= mu_valid_ff;
         rsp_valid_ff <= rm_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s <= DIV_STEPS; s++) begin
            dv_ff[s] <= dv_in[s];
         end
         mu_mant_ff  <= mu_prod[RECIP_100_SHIFT +: MANT_FULL_W];
         mu_dlo_ff   <= dv_ff[DIV_STEPS].quo[REM_W-1:0];
         mu_os8_ff   <= dv_ff[DIV_STEPS].os8;
         mu_zero_ff  <= dv_ff[DIV_STEPS].zero;
         rm_mant_ff  <= mu_mant_ff;
         rm_rem_ff   <= rm_rem_in;
         rm_os8_ff   <= mu_os8_ff;
         rm_zero_ff  <= mu_zero_ff;
         rsp_word_ff <= rsp_word_in;
         rsp_zero_ff <= rm_zero_ff;
         rsp_ovf_ff  <= rsp_ovf_in;
         rsp_os8_ff  <= rm_os8_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_divider_word      = rsp_word_ff;
   assign rsp_zero_baud_error   = rsp_zero_ff;
   assign rsp_mantissa_overflow = rsp_ovf_ff;

   a_zero_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_baud_error |-> rsp_divider_word == '0 && !rsp_mantissa_overflow)
      else $error("zero baud item with nonzero word or overflow");

   a_frac_8x: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_os8_ff |-> !rsp_divider_word[3])
      else $error("8x fraction spills into bit 3");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rm_valid_ff |-> rm_rem_ff < DEC_BASE)
      else $error("decimal remainder out of range");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rm_valid_ff) && $stable(mu_valid_ff)
         && $stable(dv_valid_ff[DIV_STEPS]))
      else $error("pipeline moved while output stalled");

endmodule
